// ----- rtl/nqb_pkg.sv -----
// Package: shared widths, microcode encoding and control program of the N-queens solver.
package nqb_pkg;

	localparam int MAX_N_DEF   = 8;
	localparam int CFG_W       = 4;
	localparam int PLACE_W     = 32;
	localparam int COUNT_W     = 24;
	localparam int PACK_BITS   = 4;
	localparam int PACK_ROWS   = PLACE_W / PACK_BITS;
	localparam int APB_W       = 32;
	localparam int PADDR_W     = 3;
	localparam logic [CFG_W-1:0]   BOARD_RESET = CFG_W'(8);
	localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

	// register select bit of paddr
	localparam logic REG_BOARD_SIZE = 1'b0;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_IDLE    = 4'd0;
	localparam step_t ST_LOAD    = 4'd1;
	localparam step_t ST_RANGE   = 4'd2;
	localparam step_t ST_DONE    = 4'd3;
	localparam step_t ST_CHECK   = 4'd4;
	localparam step_t ST_BUMP    = 4'd5;
	localparam step_t ST_FAIL    = 4'd6;
	localparam step_t ST_PLACE   = 4'd7;
	localparam step_t ST_DESCEND = 4'd8;
	localparam step_t ST_SOLVED  = 4'd9;
	localparam step_t ST_EXHAUST = 4'd10;

	typedef enum logic [3:0] {
		OP_ACCEPT,
		OP_LOAD,
		OP_NOP,
		OP_INC_I,
		OP_BUMP,
		OP_BACK,
		OP_PLACE,
		OP_DESCEND,
		OP_EMIT_SOL,
		OP_EMIT_END
	} op_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NO_START,
		C_END,
		C_COL_OVER,
		C_ROW_DONE,
		C_NO_ATTACK,
		C_ROW_LAST
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ucode_t;

	typedef struct packed {
		logic start_ok;
		logic search_end;
		logic col_over;
		logic row_done;
		logic attack;
		logic row_last;
	} status_t;

	typedef struct packed {
		op_t  op;
		logic busy;
	} ctrl_t;

	// control program: jump to target when cond holds, else fall through
	function automatic ucode_t ucode_word(input step_t pc);
		ucode_t w;
		w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE};
		unique case (pc)
			ST_IDLE:    w = '{op: OP_ACCEPT,   cond: C_NO_START,  target: ST_IDLE};
			ST_LOAD:    w = '{op: OP_LOAD,     cond: C_END,       target: ST_EXHAUST};
			ST_RANGE:   w = '{op: OP_NOP,      cond: C_COL_OVER,  target: ST_FAIL};
			ST_DONE:    w = '{op: OP_NOP,      cond: C_ROW_DONE,  target: ST_PLACE};
			ST_CHECK:   w = '{op: OP_INC_I,    cond: C_NO_ATTACK, target: ST_DONE};
			ST_BUMP:    w = '{op: OP_BUMP,     cond: C_ALWAYS,    target: ST_RANGE};
			ST_FAIL:    w = '{op: OP_BACK,     cond: C_ALWAYS,    target: ST_LOAD};
			ST_PLACE:   w = '{op: OP_PLACE,    cond: C_ROW_LAST,  target: ST_SOLVED};
			ST_DESCEND: w = '{op: OP_DESCEND,  cond: C_ALWAYS,    target: ST_LOAD};
			ST_SOLVED:  w = '{op: OP_EMIT_SOL, cond: C_ALWAYS,    target: ST_IDLE};
			ST_EXHAUST: w = '{op: OP_EMIT_END, cond: C_ALWAYS,    target: ST_IDLE};
			default:    w = '{op: OP_NOP,      cond: C_ALWAYS,    target: ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/nqb_seq.sv -----
// Microcode sequencer: step counter, control store and conditional jumps.
module nqb_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  nqb_pkg::status_t status,
	output nqb_pkg::ctrl_t   ctrl
);
	import nqb_pkg::*;

	step_t  pc_q;
	ucode_t word;
	logic   take;

	always_comb begin
		word = ucode_word(pc_q);
		unique case (word.cond)
			C_ALWAYS:    take = 1'b1;
			C_NO_START:  take = !status.start_ok;
			C_END:       take = status.search_end;
			C_COL_OVER:  take = status.col_over;
			C_ROW_DONE:  take = status.row_done;
			C_NO_ATTACK: take = !status.attack;
			C_ROW_LAST:  take = status.row_last;
			default:     take = 1'b1;
		endcase
		ctrl.op   = word.op;
		ctrl.busy = (pc_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else if (take) begin
			pc_q <= word.target;
		end else begin
			pc_q <= pc_q + STEP_W'(1);
		end
	end

	ap_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == ST_IDLE && !status.start_ok) |=> pc_q == ST_IDLE)
		else $error("sequencer left idle without a request");

endmodule

// ----- rtl/n_queens_backtrack_solver.sv -----
// Top level: N-queens backtracking solver with APB board-size register.
// Usage
//   Set board_size over the APB port (byte address 0, 4 bits, reset 8). Zero
//   counts as a 1x1 board and anything above MAX_N as MAX_N. The size is taken
//   when a search starts: on a request with restart high, or on the first
//   request after reset; later writes touch only the next search.
//   Issue a request by raising start while busy is low; restart selects a
//   fresh search, otherwise the search resumes where the last one stopped.
//   busy rises the next cycle and drops in the cycle that done pulses with
//   placement (4 bits per row, row 1 lowest, column minus one), found and
//   solution_count; the next request may be taken at that same edge. An
//   exhausted search answers found low, placement zero and the final count.
// Timing
//   One microcode step a cycle, one earlier row checked per two steps. Entering
//   a row loads the next candidate column; each candidate column is checked
//   against the board size, then against each earlier row in turn; a backtrack,
//   a descent and a report each run as their own steps.
// Reset
//   Asynchronous, active low: clears board, row, count and sequencer. The
//   receiver cannot stall; a result is valid only in its done cycle.
module n_queens_backtrack_solver #(
	parameter int MAX_N = nqb_pkg::MAX_N_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          start,
	output logic                          busy,
	input  logic                          restart,
	// result channel
	output logic                          done,
	output logic [nqb_pkg::PLACE_W-1:0]   placement,
	output logic                          found,
	output logic [nqb_pkg::COUNT_W-1:0]   solution_count,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nqb_pkg::PADDR_W-1:0]   paddr,
	input  logic [nqb_pkg::APB_W-1:0]     pwdata,
	output logic [nqb_pkg::APB_W-1:0]     prdata,
	output logic                          pready
);
	import nqb_pkg::*;

	localparam int COL_W  = $clog2(MAX_N + 2);
	localparam int IDX_W  = $clog2(MAX_N);
	localparam int NPACK  = (MAX_N < PACK_ROWS) ? MAX_N : PACK_ROWS;

	logic [CFG_W-1:0]   board_q;
	logic [COL_W-1:0]   col_q [MAX_N];
	logic [COL_W-1:0]   row_q;
	logic [COL_W-1:0]   cc_q;
	logic [COL_W-1:0]   i_q;
	logic [COL_W-1:0]   size_q;
	logic [COUNT_W-1:0] count_q;
	logic               exh_q;
	logic               started_q;
	logic               done_q;
	logic [PLACE_W-1:0] place_q;
	logic               found_q;
	logic [COUNT_W-1:0] cnt_out_q;

	status_t            status;
	ctrl_t              ctrl;
	logic [COL_W-1:0]   size_new;
	logic [COL_W-1:0]   row_m1;
	logic [COL_W-1:0]   i_m1;
	logic [IDX_W-1:0]   rd_idx;
	logic [IDX_W-1:0]   wr_idx;
	logic [COL_W-1:0]   rd_col;
	logic [COL_W-1:0]   col_gap;
	logic [COL_W-1:0]   cc_next;
	logic [PLACE_W-1:0] packed_cols;
	logic [COL_W-1:0]   col_m1;
	logic               accept;
	logic               init;
	logic               cfg_wr;

	// APB: one register, zero wait states
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BOARD_SIZE);
	assign prdata = (paddr[2] == REG_BOARD_SIZE) ? APB_W'(board_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_q <= BOARD_RESET;
		end else if (cfg_wr) begin
			board_q <= pwdata[CFG_W-1:0];
		end
	end

	// clamp the size into 1..MAX_N
	always_comb begin
		if (board_q == '0) begin
			size_new = COL_W'(1);
		end else if (int'(board_q) > MAX_N) begin
			size_new = COL_W'(MAX_N);
		end else begin
			size_new = COL_W'(board_q);
		end
	end

	assign accept = start && !ctrl.busy;
	assign init   = accept && (restart || !started_q) && (ctrl.op == OP_ACCEPT);

	// single read port: current row on load, earlier row i during the check
	assign row_m1 = row_q - COL_W'(1);
	assign i_m1   = i_q - COL_W'(1);
	assign rd_idx = (ctrl.op == OP_LOAD) ? row_m1[IDX_W-1:0] : i_m1[IDX_W-1:0];
	assign wr_idx = row_m1[IDX_W-1:0];
	assign rd_col = col_q[rd_idx];
	assign col_gap = (rd_col > cc_q) ? (rd_col - cc_q) : (cc_q - rd_col);
	assign cc_next = cc_q + COL_W'(1);

	assign status.start_ok   = accept;
	assign status.search_end = exh_q || (row_q == '0) || (row_q > size_q);
	assign status.col_over   = cc_q > size_q;
	assign status.row_done   = i_q == row_q;
	assign status.attack     = (rd_col == cc_q) || (col_gap == (row_q - i_q));
	assign status.row_last   = row_q == size_q;

	nqb_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// pack the rows that fit, rows past the board size stay zero
	always_comb begin
		packed_cols = '0;
		col_m1      = '0;
		for (int r = 0; r < NPACK; r++) begin
			col_m1 = col_q[r] - COL_W'(1);
			if (COL_W'(r) < size_q) begin
				packed_cols[r*PACK_BITS +: PACK_BITS] = PACK_BITS'(col_m1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_N; k++) begin
				col_q[k] <= '0;
			end
			row_q     <= COL_W'(1);
			cc_q      <= '0;
			i_q       <= COL_W'(1);
			size_q    <= (MAX_N < 8) ? COL_W'(MAX_N) : COL_W'(8);
			count_q   <= '0;
			exh_q     <= 1'b0;
			started_q <= 1'b0;
			done_q    <= 1'b0;
			place_q   <= '0;
			found_q   <= 1'b0;
			cnt_out_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (ctrl.op)
				OP_ACCEPT: begin
					// fresh search: clear board, latch size
					if (init) begin
						for (int k = 0; k < MAX_N; k++) begin
							col_q[k] <= '0;
						end
						row_q     <= COL_W'(1);
						count_q   <= '0;
						exh_q     <= 1'b0;
						size_q    <= size_new;
						started_q <= 1'b1;
					end
				end
				OP_LOAD: begin
					// next candidate column for this row, check from row 1
					cc_q <= rd_col + COL_W'(1);
					i_q  <= COL_W'(1);
				end
				OP_NOP: begin
				end
				OP_INC_I: begin
					i_q <= i_q + COL_W'(1);
				end
				OP_BUMP: begin
					cc_q <= cc_next;
					i_q  <= COL_W'(1);
				end
				OP_BACK: begin
					// no column left: drop this row, back up
					col_q[wr_idx] <= '0;
					row_q         <= row_m1;
				end
				OP_PLACE: begin
					col_q[wr_idx] <= cc_q;
				end
				OP_DESCEND: begin
					row_q <= row_q + COL_W'(1);
				end
				OP_EMIT_SOL: begin
					place_q   <= packed_cols;
					found_q   <= 1'b1;
					done_q    <= 1'b1;
					if (count_q != COUNT_MAX) begin
						count_q   <= count_q + COUNT_W'(1);
						cnt_out_q <= count_q + COUNT_W'(1);
					end else begin
						cnt_out_q <= count_q;
					end
					// advance past the solution column, back up if none left
					if (cc_next > size_q) begin
						col_q[wr_idx] <= '0;
						row_q         <= row_m1;
					end else begin
						col_q[wr_idx] <= cc_next;
					end
				end
				OP_EMIT_END: begin
					exh_q     <= 1'b1;
					place_q   <= '0;
					found_q   <= 1'b0;
					cnt_out_q <= count_q;
					done_q    <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign busy           = ctrl.busy;
	assign done           = done_q;
	assign placement      = place_q;
	assign found          = found_q;
	assign solution_count = cnt_out_q;

	ap_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe lasted more than one cycle");

	ap_found_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && found_q) |-> (cnt_out_q != '0))
		else $error("solution reported with zero count");

	ap_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !found_q) |-> (place_q == '0))
		else $error("exhausted result carries a placement");

	ap_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= size_q)
		else $error("current row beyond board size");

endmodule

// ----- sim/n_queens_backtrack_solver_tb.sv -----
// Testbench for the N-queens solver: directed table and random search phases checked against a predictor.
`timescale 1ns / 1ps

module n_queens_backtrack_solver_tb;
	import nqb_pkg::*;

	localparam int MAX_N            = MAX_N_DEF;
	localparam int BOARD_SIZE_INDEX = 0;
	localparam logic [PADDR_W-1:0] BOARD_SIZE_ADDR = PADDR_W'(4 * BOARD_SIZE_INDEX);
	// next word up decodes to no register; writes there must change nothing
	localparam logic [PADDR_W-1:0] SPARE_ADDR      = PADDR_W'(4 * (BOARD_SIZE_INDEX + 1));
	localparam int ITEM_TARGET  = 320;        // directed plus random requests
	localparam int QUIET_FROM   = 290;        // no sender gaps past this many requests
	localparam int SWEEP_ITEMS  = 94;         // 92 placements on 8x8, then two exhausted answers
	localparam int DRAIN_CYCLES = 64;
	// a full 8x8 sweep is the longest run; every other request is cheaper
	localparam longint CYCLE_LIMIT = 4_000_000;

	typedef struct packed {
		logic [PLACE_W-1:0] place;
		logic               found;
		logic [COUNT_W-1:0] count;
	} outcome_t;

	typedef enum {CFG_WRITE, SOLVE_REQ} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [PADDR_W-1:0] addr;
		logic [CFG_W-1:0]   value;
		logic               rs;
		bit                 typed;   // want holds a hand-derived answer
		outcome_t           want;
	} stim_row_t;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 start          = 1'b0;
	logic                 restart        = 1'b0;
	logic                 psel           = 1'b0;
	logic                 penable        = 1'b0;
	logic                 pwrite         = 1'b0;
	logic [PADDR_W-1:0]   paddr          = '0;
	logic [APB_W-1:0]     pwdata         = '0;
	logic                 busy;
	logic                 done;
	logic [PLACE_W-1:0]   placement;
	logic                 found;
	logic [COUNT_W-1:0]   solution_count;
	logic [APB_W-1:0]     prdata;
	logic                 pready;

	n_queens_backtrack_solver dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.restart        (restart),
		.done           (done),
		.placement      (placement),
		.found          (found),
		.solution_count (solution_count),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always #2 clk = ~clk;

	// Mirror of the solver: one column per row (1-based, 0 = empty), row cursor,
	// running count, and the board size latched when a search begins.
	logic [3:0]         qcol [1:MAX_N];
	logic [3:0]         cur_row     = 4'd1;
	logic [COUNT_W-1:0] sol_count   = '0;
	bit                 search_over = 1'b0;
	bit                 search_live = 1'b0;
	logic [CFG_W-1:0]   cfg_size    = BOARD_RESET;
	logic [CFG_W-1:0]   act_size    = CFG_W'(MAX_N);

	outcome_t pending_placements [$];

	int     fail_count     = 0;
	int     requests_sent  = 0;
	int     solutions_seen = 0;
	int     exhausts_seen  = 0;
	int     size_writes    = 0;
	longint cycle_count    = 0;

	initial foreach (qcol[k]) qcol[k] = '0;

	// Advance the mirrored search by one request and return the answer it gives.
	function automatic outcome_t next_placement(input logic rs);
		outcome_t o;
		int n, r, i, a, b;
		bit hit;
		o = '0;
		// a restart, or the first request after reset, latches the board size
		if (rs || !search_live) begin
			foreach (qcol[k]) qcol[k] = '0;
			cur_row     = 4'd1;
			sol_count   = '0;
			search_over = 1'b0;
			search_live = 1'b1;
			if (cfg_size == 0)
				act_size = 1;
			else if (cfg_size > MAX_N)
				act_size = CFG_W'(MAX_N);
			else
				act_size = cfg_size;
		end
		n = act_size;
		while (!search_over && cur_row > 0 && cur_row <= n) begin
			r = cur_row;
			qcol[r]++;
			// slide right past every column attacked from a row above
			forever begin
				if (qcol[r] > n)
					break;
				hit = 1'b0;
				for (i = 1; i < r; i++) begin
					a = qcol[i];
					b = qcol[r];
					if (a == b || (a > b ? a - b : b - a) == r - i)
						hit = 1'b1;
				end
				if (!hit)
					break;
				qcol[r]++;
			end
			if (qcol[r] <= n) begin
				if (r == n) begin
					// only the first eight rows fit the packed field
					for (i = 1; i <= n && i <= PACK_ROWS; i++)
						o.place |= PLACE_W'((qcol[i] - 4'd1) & 4'hF) << ((i - 1) * PACK_BITS);
					if (sol_count != COUNT_MAX)
						sol_count++;
					qcol[r]++;
					if (qcol[r] > n) begin
						qcol[r] = '0;
						cur_row = 4'(r - 1);
					end
					o.found = 1'b1;
					o.count = sol_count;
					return o;
				end
				cur_row = 4'(r + 1);
			end else begin
				qcol[r] = '0;
				cur_row = 4'(r - 1);
			end
		end
		search_over = 1'b1;
		o.count     = sol_count;
		return o;
	endfunction

	// Drop start and hold until no answer is outstanding and the block is idle.
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending_placements.size() != 0 || busy);
	endtask

	task automatic idle_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Raise a request and hold it until accepted; start stays high so a
	// back-to-back request needs no second assignment in the same step.
	task automatic issue_request(input logic rs, input bit typed, input outcome_t typed_ans);
		outcome_t guess;
		start   <= 1'b1;
		restart <= rs;
		do @(posedge clk); while (busy);
		guess = next_placement(rs);
		pending_placements.push_back(typed ? typed_ans : guess);
		requests_sent++;
	endtask

	// APB write: setup cycle, then access cycle until pready; only while idle.
	task automatic board_write(input logic [PADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		// upper data bits are junk the register must discard
		pwdata  <= {(APB_W - CFG_W)'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if ((addr >> 2) == BOARD_SIZE_INDEX) begin
			cfg_size = value;
			size_writes++;
		end
	endtask

	// Directed rows. Typed answers: the first 8x8 solution is columns
	// 1 5 8 6 3 7 2 4, the two 4x4 solutions are 2 4 1 3 and 3 1 4 2,
	// a 1x1 board has one trivial placement, 2x2 and 3x3 have none.
	stim_row_t directed_rows [30] = '{
		// first request after reset starts an 8x8 search without restart
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b0, 1'b1, '{32'h3162_5740, 1'b1, 24'd1}},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b0, 1'b0, '0},
		// size write mid-search: the running 8x8 search keeps its size
		'{CFG_WRITE, BOARD_SIZE_ADDR, 4'd4,  1'b0, 1'b0, '0},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b0, 1'b0, '0},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b1, 1'b1, '{32'h0000_2031, 1'b1, 24'd1}},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b0, 1'b1, '{32'h0000_1302, 1'b1, 24'd2}},
		// exhausted search answers the total, and keeps doing so
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b0, 1'b1, '{32'h0,        1'b0, 24'd2}},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b0, 1'b1, '{32'h0,        1'b0, 24'd2}},
		'{CFG_WRITE, BOARD_SIZE_ADDR, 4'd1,  1'b0, 1'b0, '0},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b1, 1'b1, '{32'h0,        1'b1, 24'd1}},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b0, 1'b1, '{32'h0,        1'b0, 24'd1}},
		// zero clamps up to a 1x1 board
		'{CFG_WRITE, BOARD_SIZE_ADDR, 4'd0,  1'b0, 1'b0, '0},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b1, 1'b1, '{32'h0,        1'b1, 24'd1}},
		'{CFG_WRITE, BOARD_SIZE_ADDR, 4'd2,  1'b0, 1'b0, '0},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b1, 1'b1, '{32'h0,        1'b0, 24'd0}},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b0, 1'b1, '{32'h0,        1'b0, 24'd0}},
		'{CFG_WRITE, BOARD_SIZE_ADDR, 4'd3,  1'b0, 1'b0, '0},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b1, 1'b1, '{32'h0,        1'b0, 24'd0}},
		// largest code clamps down to MAX_N
		'{CFG_WRITE, BOARD_SIZE_ADDR, 4'd15, 1'b0, 1'b0, '0},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b1, 1'b1, '{32'h3162_5740, 1'b1, 24'd1}},
		// write to an unmapped word: size stays at the clamped 15
		'{CFG_WRITE, SPARE_ADDR,      4'd1,  1'b0, 1'b0, '0},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b1, 1'b1, '{32'h3162_5740, 1'b1, 24'd1}},
		'{CFG_WRITE, BOARD_SIZE_ADDR, 4'd9,  1'b0, 1'b0, '0},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b0, 1'b0, '0},
		'{CFG_WRITE, BOARD_SIZE_ADDR, 4'd6,  1'b0, 1'b0, '0},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b1, 1'b0, '0},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b0, 1'b0, '0},
		'{CFG_WRITE, BOARD_SIZE_ADDR, 4'd7,  1'b0, 1'b0, '0},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b1, 1'b0, '0},
		'{SOLVE_REQ, BOARD_SIZE_ADDR, 4'd0,  1'b0, 1'b0, '0}
	};

	// Answer check: each done pulse is compared against the oldest expectation.
	always @(posedge clk) begin : check_answers
		outcome_t want;
		if (arst_n && done) begin
			if (pending_placements.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected answer placement %h found %b count %0d",
					$time, placement, found, solution_count);
			end else begin
				want = pending_placements.pop_front();
				if (placement !== want.place) begin
					fail_count++;
					$display("%0t: placement expected %h actual %h", $time, want.place, placement);
				end
				if (found !== want.found) begin
					fail_count++;
					$display("%0t: found expected %b actual %b", $time, want.found, found);
				end
				if (solution_count !== want.count) begin
					fail_count++;
					$display("%0t: solution_count expected %0d actual %0d",
						$time, want.count, solution_count);
				end
			end
			if (found === 1'b1)
				solutions_seen++;
			else
				exhausts_seen++;
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: cycle limit hit with %0d answers outstanding",
				$time, pending_placements.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : stimulus
		int  len, sz, k;
		bit  rs;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == CFG_WRITE)
				board_write(directed_rows[i].addr, directed_rows[i].value);
			else
				issue_request(directed_rows[i].rs, directed_rows[i].typed, directed_rows[i].want);
		end

		// Sweep a full-size board to exhaustion, with sender gaps now and then.
		board_write(BOARD_SIZE_ADDR, CFG_W'($urandom_range(MAX_N, 15)));
		for (k = 0; k < SWEEP_ITEMS; k++) begin
			if (k > 0 && $urandom_range(0, 3) == 0)
				idle_sender($urandom_range(1, 11));
			issue_request(k == 0, 1'b0, '0);
		end

		// Random phases: mostly small boards, an occasional large or clamped code.
		// A phase may open without restart, which must keep the old search and size.
		while (requests_sent < ITEM_TARGET) begin
			sz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(4, 7);
			// register writes drain the block, so keep them out of the closing stretch
			if (requests_sent < QUIET_FROM) begin
				if ($urandom_range(0, 7) == 0)
					board_write(SPARE_ADDR, CFG_W'($urandom));
				if ($urandom_range(0, 4) != 0)
					board_write(BOARD_SIZE_ADDR, CFG_W'(sz));
			end
			len = $urandom_range(2, 16);
			for (k = 0; k < len; k++) begin
				rs = (k == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 15) == 0);
				// gaps and full drains only before the closing stretch
				if (requests_sent < QUIET_FROM) begin
					if ($urandom_range(0, 2) == 0)
						idle_sender($urandom_range(1, 11));
					else if ($urandom_range(0, 19) == 0)
						settle();
				end
				issue_request(rs, 1'b0, '0);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d solver requests over %0d board-size writes, incl. a full 8x8 sweep.",
			requests_sent, size_writes);
		$display("Answers seen: %0d placements, %0d exhausted-search replies.",
			solutions_seen, exhausts_seen);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
